>>> design/ddfpv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ddfpv_pkg;

  localparam int unsigned HALF_TRACK_DEF = 393216;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_ACCEL_GAIN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_ACCEL_GAIN     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_STATIC_MV  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_STATIC_MV      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROPORTIONAL_GAIN   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_WINDOW     = 4'd7;

  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 66;
  localparam int unsigned V_W    = 52;
  localparam int unsigned NUM_W  = 66;
  localparam int unsigned Q_W    = 25;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned SUM_W  = 48;

  localparam int unsigned RECIP_100   = 1374389535;
  localparam int unsigned RECIP_SHIFT = 37;
  localparam int unsigned SCALE_STEPS = 15;
  localparam int unsigned LIMIT_MV    = 12000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TURN, ST_ACCV, ST_ACCW, ST_WL, ST_WR, ST_AS, ST_AT, ST_PL, ST_PR,
    ST_PRC, ST_INT, ST_DIV, ST_SUM, ST_IHI, ST_ILO, ST_ITERM, ST_STAT, ST_SCHK,
    ST_SLO, ST_SHI, ST_SNUM, ST_SRES, ST_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/ddfpv_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface ddfpv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_linear;
  logic signed [31:0] target_angular;
  logic signed [31:0] measured_left;
  logic signed [31:0] measured_right;
  modport source (output valid, target_linear, target_angular, measured_left,
                  measured_right, input ready);
  modport sink (input valid, target_linear, target_angular, measured_left,
                measured_right, output ready);
endinterface

interface ddfpv_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] left_mv;
  logic signed [14:0] right_mv;
  logic               was_scaled;
  modport source (output valid, left_mv, right_mv, was_scaled, input ready);
  modport sink (input valid, left_mv, right_mv, was_scaled, output ready);
endinterface

interface ddfpv_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/diff_drive_ff_pi_voltage.sv
`timescale 1ns / 1ps
`default_nettype none
// Differential-drive wheel voltage controller, one update per control tick.
// The input channel takes one beat per tick: target linear and angular velocity
// and the two measured wheel velocities, signed Q16.16. The output channel
// returns one beat per input beat with the left and right drive voltages in
// millivolts and a flag that is set when the pair was scaled to the limit.
// The configuration channel writes at most one register per beat and is always
// ready; it should be written only while no update is in progress.
// An update uses one shared 33 by 33 bit multiplier for every product, the
// integral increment's division by a hundred included as a reciprocal product,
// and one shared long divider that takes 15 steps per wheel when the pair is
// scaled. The input is ready only while no update is in progress.
// Reset clears the configuration registers, the stored targets, errors and integrals, and
// the output beat. A finished result waits in the output register while the
// receiver stalls; the next input beat is then accepted and computed, and its
// result is held back until the waiting beat has been taken.
module diff_drive_ff_pi_voltage
  import ddfpv_pkg::*;
#(
  parameter int unsigned HALF_TRACK_Q16 = HALF_TRACK_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  ddfpv_in_if.sink       in_ch,
  ddfpv_out_if.source    out_ch,
  ddfpv_cfg_if.sink      cfg_ch
);

  state_t state_r, state_nxt;

  logic signed [31:0] kv_r, ksa_r, kta_r, kp_r, ki_r;
  logic [13:0]        ss_r, st_r;
  logic [30:0]        win_r;

  logic signed [31:0] lin_r, ang_r, ml_r, mr_r;
  logic signed [31:0] last_lin_r, last_ang_r, last_el_r, last_er_r;
  logic signed [SUM_W-1:0] sum_l_r, sum_r_r, sumw_r;
  logic signed [31:0] wl_r, wr_r, el_r, er_r, accv_r, accw_r;
  logic signed [V_W-1:0] vl_r, vr_r;
  logic [V_W-1:0]     m_r;
  logic signed [PROD_W-1:0] prod_r, tmp_r;
  logic               side_r, neg_r;

  logic [NUM_W-1:0]   div_rem_r, div_den_r;
  logic [Q_W-1:0]     div_q_r;
  logic [CNT_W-1:0]   div_cnt_r;

  logic signed [14:0] res_l_r, res_r_r;
  logic               scaled_r;
  logic               out_valid_r;
  logic signed [14:0] out_left_r, out_right_r;
  logic               out_scaled_r;

  logic signed [MUL_W-1:0] mul_a, mul_b;

  function automatic logic signed [V_W-1:0] static_term(input logic signed [31:0] x,
                                                        input logic [13:0] mv);
    logic signed [V_W-1:0] t;
    t = $signed({{(V_W-30){1'b0}}, mv, 16'd0});
    if (x > 32'sd0) begin
      return t;
    end else if (x < 32'sd0) begin
      return -t;
    end
    return '0;
  endfunction

  logic signed [V_W-1:0] fq;
  logic signed [50:0]    wsum_l, wsum_r;
  logic signed [32:0]    dlin, dang;
  logic signed [31:0]    e_sel, last_sel;
  logic signed [SUM_W-1:0] sum_sel;
  logic [32:0]           abse;
  logic                  integ;
  logic                  div_ge;
  logic [NUM_W-1:0]      div_sub;
  logic [Q_W-1:0]        int_q;
  logic signed [SUM_W:0] sum_new;
  logic signed [PROD_W-1:0] iterm_raw;
  logic signed [SUM_W-1:0]  iterm;
  logic signed [V_W-1:0] v_sel;
  logic [V_W-1:0]        absv, absl, absr, mmax;
  logic [V_W-1:0]        rnd_l, rnd_r;

  always_comb begin
    fq      = {{(V_W-50){prod_r[PROD_W-1]}}, prod_r[PROD_W-1:16]};
    wsum_l  = {{19{lin_r[31]}}, lin_r} - {prod_r[PROD_W-1], prod_r[PROD_W-1:16]};
    wsum_r  = {{19{lin_r[31]}}, lin_r} + {prod_r[PROD_W-1], prod_r[PROD_W-1:16]};
    dlin    = {lin_r[31], lin_r} - {last_lin_r[31], last_lin_r};
    dang    = {ang_r[31], ang_r} - {last_ang_r[31], last_ang_r};
    e_sel   = side_r ? er_r : el_r;
    last_sel = side_r ? last_er_r : last_el_r;
    sum_sel = side_r ? sum_r_r : sum_l_r;
    abse    = e_sel[31] ? 33'(-{e_sel[31], e_sel}) : {1'b0, e_sel};
    integ   = abse < {2'b00, win_r};
    div_ge  = div_rem_r >= div_den_r;
    div_sub = div_rem_r - div_den_r;
    int_q   = prod_r[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
    sum_new = neg_r ? {sumw_r[SUM_W-1], sumw_r} - $signed({{(SUM_W+1-Q_W){1'b0}}, int_q})
                    : {sumw_r[SUM_W-1], sumw_r} + $signed({{(SUM_W+1-Q_W){1'b0}}, int_q});
    iterm_raw = tmp_r + {{16{prod_r[PROD_W-1]}}, prod_r[PROD_W-1:16]};
    if (iterm_raw > 66'sd140737488355327) begin
      iterm = 48'sh7FFFFFFFFFFF;
    end else if (iterm_raw < -66'sd140737488355327) begin
      iterm = -48'sh7FFFFFFFFFFF;
    end else begin
      iterm = iterm_raw[SUM_W-1:0];
    end
    v_sel = side_r ? vr_r : vl_r;
    absv  = v_sel[V_W-1] ? V_W'(-v_sel) : V_W'(v_sel);
    absl  = vl_r[V_W-1] ? V_W'(-vl_r) : V_W'(vl_r);
    absr  = vr_r[V_W-1] ? V_W'(-vr_r) : V_W'(vr_r);
    mmax  = (absl > absr) ? absl : absr;
    rnd_l = (absl + V_W'(32768)) >> 16;
    rnd_r = (absr + V_W'(32768)) >> 16;
  end

  always_comb begin
    state_nxt = state_r;
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_TURN;
      ST_TURN: begin
        mul_a = {ang_r[31], ang_r};
        mul_b = MUL_W'(HALF_TRACK_Q16);
        state_nxt = ST_ACCV;
      end
      ST_ACCV: begin
        mul_a = dlin;
        mul_b = 33'sd100;
        state_nxt = ST_ACCW;
      end
      ST_ACCW: begin
        mul_a = dang;
        mul_b = 33'sd100;
        state_nxt = ST_WL;
      end
      ST_WL: begin
        mul_a = {kv_r[31], kv_r};
        mul_b = {wl_r[31], wl_r};
        state_nxt = ST_WR;
      end
      ST_WR: begin
        mul_a = {kv_r[31], kv_r};
        mul_b = {wr_r[31], wr_r};
        state_nxt = ST_AS;
      end
      ST_AS: begin
        mul_a = {ksa_r[31], ksa_r};
        mul_b = {accv_r[31], accv_r};
        state_nxt = ST_AT;
      end
      ST_AT: begin
        mul_a = {kta_r[31], kta_r};
        mul_b = {accw_r[31], accw_r};
        state_nxt = ST_PL;
      end
      ST_PL: begin
        mul_a = {kp_r[31], kp_r};
        mul_b = {el_r[31], el_r};
        state_nxt = ST_PR;
      end
      ST_PR: begin
        mul_a = {kp_r[31], kp_r};
        mul_b = {er_r[31], er_r};
        state_nxt = ST_PRC;
      end
      ST_PRC:   state_nxt = ST_INT;
      ST_INT: begin
        mul_a = integ ? {1'b0, abse[31:0] + 32'd50} : '0;
        mul_b = MUL_W'(RECIP_100);
        state_nxt = ST_SUM;
      end
      ST_DIV: begin
        if (div_cnt_r == CNT_W'(1)) begin
          state_nxt = ST_SRES;
        end
      end
      ST_SUM:   state_nxt = side_r ? ST_IHI : ST_INT;
      ST_IHI: begin
        mul_a = {ki_r[31], ki_r};
        mul_b = {sum_sel[SUM_W-1], sum_sel[SUM_W-1:16]};
        state_nxt = ST_ILO;
      end
      ST_ILO: begin
        mul_a = {ki_r[31], ki_r};
        mul_b = {17'd0, sum_sel[15:0]};
        state_nxt = ST_ITERM;
      end
      ST_ITERM: state_nxt = side_r ? ST_STAT : ST_IHI;
      ST_STAT:  state_nxt = ST_SCHK;
      ST_SCHK:  state_nxt = (mmax > V_W'(LIMIT_MV * 65536)) ? ST_SLO : ST_DONE;
      ST_SLO: begin
        mul_a = {7'd0, absv[25:0]};
        mul_b = MUL_W'(LIMIT_MV);
        state_nxt = ST_SHI;
      end
      ST_SHI: begin
        mul_a = {8'd0, absv[50:26]};
        mul_b = MUL_W'(LIMIT_MV);
        state_nxt = ST_SNUM;
      end
      ST_SNUM:  state_nxt = ST_DIV;
      ST_SRES:  state_nxt = side_r ? ST_DONE : ST_SLO;
      ST_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kv_r <= '0; ksa_r <= '0; kta_r <= '0; kp_r <= '0; ki_r <= '0;
      ss_r <= '0; st_r <= '0; win_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_VELOCITY_GAIN:       kv_r  <= cfg_ch.data;
        CFG_STRAIGHT_ACCEL_GAIN: ksa_r <= cfg_ch.data;
        CFG_TURN_ACCEL_GAIN:     kta_r <= cfg_ch.data;
        CFG_STRAIGHT_STATIC_MV:  ss_r  <= cfg_ch.data[13:0];
        CFG_TURN_STATIC_MV:      st_r  <= cfg_ch.data[13:0];
        CFG_PROPORTIONAL_GAIN:   kp_r  <= cfg_ch.data;
        CFG_INTEGRAL_GAIN:       ki_r  <= cfg_ch.data;
        CFG_INTEGRAL_WINDOW:     win_r <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      last_lin_r <= '0; last_ang_r <= '0; last_el_r <= '0; last_er_r <= '0;
      sum_l_r <= '0; sum_r_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          lin_r <= in_ch.target_linear;
          ang_r <= in_ch.target_angular;
          ml_r  <= in_ch.measured_left;
          mr_r  <= in_ch.measured_right;
        end
        ST_ACCV: begin
          wl_r <= sat32({{15{wsum_l[50]}}, wsum_l});
          wr_r <= sat32({{15{wsum_r[50]}}, wsum_r});
        end
        ST_ACCW: begin
          accv_r <= sat32(prod_r);
          el_r <= sat32({{34{wl_r[31]}}, wl_r} - {{34{ml_r[31]}}, ml_r});
          er_r <= sat32({{34{wr_r[31]}}, wr_r} - {{34{mr_r[31]}}, mr_r});
        end
        ST_WL: begin
          accw_r <= sat32(prod_r);
          last_lin_r <= lin_r;
          last_ang_r <= ang_r;
          vl_r <= '0;
          vr_r <= '0;
        end
        ST_WR:  vl_r <= vl_r + fq;
        ST_AS:  vr_r <= vr_r + fq;
        ST_AT: begin
          vl_r <= vl_r + fq;
          vr_r <= vr_r + fq;
        end
        ST_PL: begin
          vl_r <= vl_r - fq;
          vr_r <= vr_r + fq;
        end
        ST_PR:  vl_r <= vl_r + fq;
        ST_PRC: begin
          vr_r <= vr_r + fq;
          side_r <= 1'b0;
        end
        ST_INT: begin
          sumw_r <= (e_sel[31] != last_sel[31]) ? '0 : sum_sel;
          neg_r <= e_sel[31];
          if (side_r) last_er_r <= e_sel;
          else last_el_r <= e_sel;
        end
        ST_DIV: begin
          div_q_r <= {div_q_r[Q_W-2:0], div_ge};
          if (div_ge) div_rem_r <= div_sub;
          div_den_r <= div_den_r >> 1;
          div_cnt_r <= div_cnt_r - CNT_W'(1);
        end
        ST_SUM: begin
          if (sum_new[SUM_W] != sum_new[SUM_W-1]) begin
            if (side_r) sum_r_r <= sum_new[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                  : {1'b0, {(SUM_W-1){1'b1}}};
            else sum_l_r <= sum_new[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
          end else begin
            if (side_r) sum_r_r <= sum_new[SUM_W-1:0];
            else sum_l_r <= sum_new[SUM_W-1:0];
          end
          side_r <= ~side_r;
        end
        ST_ILO:   tmp_r <= prod_r;
        ST_ITERM: begin
          if (side_r) vr_r <= vr_r + {{(V_W-SUM_W){iterm[SUM_W-1]}}, iterm};
          else vl_r <= vl_r + {{(V_W-SUM_W){iterm[SUM_W-1]}}, iterm};
          side_r <= ~side_r;
        end
        ST_STAT: begin
          vl_r <= vl_r + static_term(wl_r, ss_r) - static_term(ang_r, st_r);
          vr_r <= vr_r + static_term(wr_r, ss_r) + static_term(ang_r, st_r);
        end
        ST_SCHK: begin
          m_r <= mmax;
          side_r <= 1'b0;
          scaled_r <= mmax > V_W'(LIMIT_MV * 65536);
          res_l_r <= vl_r[V_W-1] ? -rnd_l[14:0] : rnd_l[14:0];
          res_r_r <= vr_r[V_W-1] ? -rnd_r[14:0] : rnd_r[14:0];
        end
        ST_SLO:   neg_r <= v_sel[V_W-1];
        ST_SHI:   tmp_r <= prod_r;
        ST_SNUM: begin
          div_q_r <= '0;
          div_rem_r <= {prod_r[39:0], 26'd0} + NUM_W'($unsigned(tmp_r))
                       + {15'd0, m_r[V_W-1:1]};
          div_den_r <= {m_r, 14'd0};
          div_cnt_r <= CNT_W'(SCALE_STEPS);
        end
        ST_SRES: begin
          if (side_r) res_r_r <= neg_r ? -div_q_r[14:0] : div_q_r[14:0];
          else res_l_r <= neg_r ? -div_q_r[14:0] : div_q_r[14:0];
          side_r <= ~side_r;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_left_r <= res_l_r;
            out_right_r <= res_r_r;
            out_scaled_r <= scaled_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.left_mv    = out_left_r;
  assign out_ch.right_mv   = out_right_r;
  assign out_ch.was_scaled = out_scaled_r;

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_TURN))
    else $error("update did not start after an input beat");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r != '0))
    else $error("divider running with an empty step count");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || out_ch.ready))
      |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not moved to the output register");

  a_scaled_hits_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scaled_r) |->
      (out_left_r == 15'sd12000 || out_left_r == -15'sd12000 ||
       out_right_r == 15'sd12000 || out_right_r == -15'sd12000))
    else $error("scaled pair does not reach the limit");

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ddfpv_pkg::*;

  typedef struct packed {
    logic signed [31:0] lin;
    logic signed [31:0] ang;
    logic signed [31:0] ml;
    logic signed [31:0] mr;
  } tick_t;

  typedef struct packed {
    logic signed [14:0] left;
    logic signed [14:0] right;
    logic               scaled;
  } drive_t;

  localparam longint Q_ONE     = 65536;
  localparam longint MV_LIMIT  = 12000;
  localparam longint SUM_HI    = 64'sd140737488355327;
  localparam longint SUM_LO    = -SUM_HI - 1;
  localparam int     IDLE_LIMIT = 20000;
  localparam int     SETTLE     = 130;
  localparam int     LONG_HOLD  = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ddfpv_in_if  in_bus ();
  ddfpv_out_if out_bus ();
  ddfpv_cfg_if cfg_bus ();

  diff_drive_ff_pi_voltage dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #4 clk = ~clk;

  // Predictor copy of the registers and the controller state.
  longint kv, ka_s, ka_t, ks_s, ks_t, kp, ki, win;
  longint prev_lin, prev_ang, prev_el, prev_er, isum_l, isum_r;

  tick_t  pending_ticks[$];
  drive_t drive_q[$];
  tick_t  cur_tick;

  int errors = 0;
  int n_ticks = 0, n_drives = 0, n_scaled = 0, n_cfg = 0;
  int burst_left = 0, gap_left = 0, idle_cnt = 0, hold_cnt = 0;
  int tx_mode = 0, rx_mode = 0;
  logic hold_start = 1'b0;
  longint walk_lin = 0, walk_ang = 0;

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint clip32(longint x);
    return clip(x, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint div_round(longint num, longint den);
    if (num >= 0) begin
      return (num + den / 2) / den;
    end
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint sign_of(longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint next_sum(longint e, longint last, longint sum);
    longint s;
    s = sum;
    if ((e < 0) != (last < 0)) begin
      s = 0;
    end
    if (mag(e) < win) begin
      s = clip(s + div_round(e, 100), SUM_LO, SUM_HI);
    end
    return s;
  endfunction

  function automatic longint int_term(longint sum);
    longint hi, lo, t;
    hi = sum >>> 16;
    lo = sum - hi * Q_ONE;
    t = ki * hi + ((ki * lo) >>> 16);
    return clip(t, -SUM_HI, SUM_HI);
  endfunction

  function automatic drive_t wheel_voltages(tick_t t);
    longint lin, ang, ml, mr, acc_v, acc_w, turn, wl, wr, el, er;
    longint a_s, a_t, s_t, vl, vr, m, ol, orr;
    drive_t d;
    lin = t.lin;
    ang = t.ang;
    ml = t.ml;
    mr = t.mr;
    acc_v = clip32((lin - prev_lin) * 100);
    acc_w = clip32((ang - prev_ang) * 100);
    prev_lin = lin;
    prev_ang = ang;
    turn = (ang * longint'(HALF_TRACK_DEF)) >>> 16;
    wl = clip32(lin - turn);
    wr = clip32(lin + turn);
    el = clip32(wl - ml);
    er = clip32(wr - mr);
    isum_l = next_sum(el, prev_el, isum_l);
    prev_el = el;
    isum_r = next_sum(er, prev_er, isum_r);
    prev_er = er;
    a_s = (ka_s * acc_v) >>> 16;
    a_t = (ka_t * acc_w) >>> 16;
    s_t = ks_t * Q_ONE * sign_of(ang);
    vl = ((kv * wl) >>> 16) + (a_s - a_t) + ks_s * Q_ONE * sign_of(wl) - s_t
         + ((kp * el) >>> 16) + int_term(isum_l);
    vr = ((kv * wr) >>> 16) + (a_s + a_t) + ks_s * Q_ONE * sign_of(wr) + s_t
         + ((kp * er) >>> 16) + int_term(isum_r);
    m = (mag(vl) > mag(vr)) ? mag(vl) : mag(vr);
    if (m > MV_LIMIT * Q_ONE) begin
      ol = div_round(vl * MV_LIMIT, m);
      orr = div_round(vr * MV_LIMIT, m);
      d.scaled = 1'b1;
    end else begin
      ol = div_round(vl, Q_ONE);
      orr = div_round(vr, Q_ONE);
      d.scaled = 1'b0;
    end
    d.left = ol[14:0];
    d.right = orr[14:0];
    return d;
  endfunction

  function automatic longint noise(longint amp);
    return longint'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    longint amp, wl, wr;
    if ($urandom_range(0, 99) < 12) begin
      t.lin = $urandom;
      t.ang = $urandom;
      t.ml = $urandom;
      t.mr = $urandom;
    end else begin
      walk_lin = clip(walk_lin + noise(40000), -400000, 400000);
      walk_ang = clip(walk_ang + noise(30000), -300000, 300000);
      amp = longint'($urandom_range(500, 200000));
      wl = walk_lin - walk_ang * 6;
      wr = walk_lin + walk_ang * 6;
      t.lin = walk_lin;
      t.ang = walk_ang;
      t.ml = wl + noise(amp);
      t.mr = wr + noise(amp);
    end
    return t;
  endfunction

  function automatic tick_t mk_tick(longint a, longint b, longint c, longint d);
    tick_t t;
    t.lin = a;
    t.ang = b;
    t.ml = c;
    t.mr = d;
    return t;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) begin
      @(posedge clk);
    end
    cfg_bus.valid <= 1'b0;
    n_cfg++;
    case (idx)
      CFG_VELOCITY_GAIN:       kv = $signed(val);
      CFG_STRAIGHT_ACCEL_GAIN: ka_s = $signed(val);
      CFG_TURN_ACCEL_GAIN:     ka_t = $signed(val);
      CFG_STRAIGHT_STATIC_MV:  ks_s = longint'(val[13:0]);
      CFG_TURN_STATIC_MV:      ks_t = longint'(val[13:0]);
      CFG_PROPORTIONAL_GAIN:   kp = $signed(val);
      CFG_INTEGRAL_GAIN:       ki = $signed(val);
      CFG_INTEGRAL_WINDOW:     win = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic load_settings(int kind);
    logic [31:0] v[8];
    case (kind)
      0: begin
        v[0] = $urandom_range(0, 1 << 22);
        v[1] = $urandom_range(0, 1 << 12);
        v[2] = -$urandom_range(0, 1 << 12);
        v[3] = $urandom_range(0, 1500);
        v[4] = $urandom_range(0, 1500);
        v[5] = $urandom_range(0, 1 << 22);
        v[6] = $urandom_range(0, 1 << 24);
        v[7] = $urandom_range(1 << 10, 1 << 18);
      end
      1: begin
        v = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd12000, 32'd12000,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
      end
      2: begin
        v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h3FFF, 32'h3FFF,
              32'h80000000, 32'h80000000, 32'd0};
      end
      default: begin
        foreach (v[i]) v[i] = $urandom;
      end
    endcase
    write_reg(CFG_VELOCITY_GAIN, v[0]);
    write_reg(CFG_STRAIGHT_ACCEL_GAIN, v[1]);
    write_reg(CFG_TURN_ACCEL_GAIN, v[2]);
    write_reg(CFG_STRAIGHT_STATIC_MV, v[3]);
    write_reg(CFG_TURN_STATIC_MV, v[4]);
    write_reg(CFG_PROPORTIONAL_GAIN, v[5]);
    write_reg(CFG_INTEGRAL_GAIN, v[6]);
    write_reg(CFG_INTEGRAL_WINDOW, v[7]);
    // Indexes past the register list must leave every register unchanged.
    write_reg(CFG_INTEGRAL_WINDOW + 4'd1 + 4'($urandom_range(0, 7)), $urandom);
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || drive_q.size() != 0 || in_bus.valid) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Input driver: bursts of beats, separated by random gaps when tx_mode is 1.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        drive_q.push_back(wheel_voltages(cur_tick));
        n_ticks++;
      end
      if (in_bus.valid && !in_bus.ready) begin
        in_bus.valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_bus.valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        cur_tick = pending_ticks.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.target_linear <= cur_tick.lin;
        in_bus.target_angular <= cur_tick.ang;
        in_bus.measured_left <= cur_tick.ml;
        in_bus.measured_right <= cur_tick.mr;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= (tx_mode == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Output receiver: its own stall pattern plus an occasional long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (hold_start) begin
        hold_cnt <= LONG_HOLD;
        out_bus.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_bus.ready <= 1'b0;
      end else if (rx_mode == 0) begin
        out_bus.ready <= 1'b1;
      end else if (rx_mode == 1) begin
        out_bus.ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_bus.ready <= ($urandom_range(0, 9) < 4);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    drive_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      n_drives++;
      if (drive_q.size() == 0) begin
        $display("unexpected result beat at %0t", $time);
        errors++;
      end else begin
        want = drive_q.pop_front();
        if (out_bus.was_scaled) n_scaled++;
        if (out_bus.left_mv !== want.left) report("left_mv", out_bus.left_mv, want.left);
        if (out_bus.right_mv !== want.right) report("right_mv", out_bus.right_mv, want.right);
        if (out_bus.was_scaled !== want.scaled)
          report("was_scaled", out_bus.was_scaled, want.scaled);
      end
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.target_linear = '0;
    in_bus.target_angular = '0;
    in_bus.measured_left = '0;
    in_bus.measured_right = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    {kv, ka_s, ka_t, ks_s, ks_t, kp, ki, win} = '0;
    {prev_lin, prev_ang, prev_el, prev_er, isum_l, isum_r} = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_settings(0);
    pending_ticks.push_back(mk_tick(0, 0, 0, 0));
    pending_ticks.push_back(mk_tick(65536, 0, 60000, 60000));
    pending_ticks.push_back(mk_tick(65536, 0, 70000, 70000));
    pending_ticks.push_back(mk_tick(65536, 0, 66000, 64000));
    pending_ticks.push_back(mk_tick(-65536, 32768, -70000, -50000));
    pending_ticks.push_back(mk_tick(64'sd2147483647, 0, 0, 0));
    pending_ticks.push_back(mk_tick(-64'sd2147483648, 0, 0, 0));
    pending_ticks.push_back(mk_tick(0, 64'sd2147483647, 0, 0));
    pending_ticks.push_back(mk_tick(0, -64'sd2147483648, 0, 0));
    pending_ticks.push_back(mk_tick(0, 0, 64'sd2147483647, -64'sd2147483648));
    pending_ticks.push_back(mk_tick(0, 0, -64'sd2147483648, 64'sd2147483647));
    pending_ticks.push_back(mk_tick(64'sd2147483647, 64'sd2147483647,
                                    -64'sd2147483648, -64'sd2147483648));
    pending_ticks.push_back(mk_tick(-64'sd2147483648, -64'sd2147483648,
                                    64'sd2147483647, 64'sd2147483647));
    pending_ticks.push_back(mk_tick(0, 0, 0, 0));
    pending_ticks.push_back(mk_tick(0, 100000, 0, 0));
    pending_ticks.push_back(mk_tick(0, -100000, 0, 0));
    pending_ticks.push_back(mk_tick(200000, 0, 200000, 200000));
    pending_ticks.push_back(mk_tick(-1, -1, -1, -1));
    drain();

    for (int ph = 1; ph <= 9; ph++) begin
      tx_mode = ph % 2;
      rx_mode = ph % 3;
      load_settings((ph < 4) ? (ph - 1) : ((ph % 4 == 3) ? 3 : 0));
      for (int i = 0; i < 190; i++) begin
        pending_ticks.push_back(random_tick());
      end
      if (ph == 4) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      drain();
    end

    $display("Checked %0d ticks and %0d drive results (%0d scaled) over %0d register writes.",
             n_ticks, n_drives, n_scaled, n_cfg);
    $display("Settings covered zero, extreme and random gains with sender and receiver stalls.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/ddfpv_pkg.sv
design/ddfpv_ifs.sv
design/diff_drive_ff_pi_voltage.sv
bench/tb_top.sv
